// ----- hw/rtl/rse_pkg.sv -----
// Shared constants, types and table builders for the static rANS encoder.
// Used by rse_rom, rse_div and rans_static_encoder; depends on nothing.
package rse_pkg;

  localparam int SECURITY_MODE = 2;
  localparam int PROB_BITS     = 16;

  localparam logic [31:0] LOW_BOUND = 32'd8388608;

  localparam int MODE_IDX = (SECURITY_MODE == 3) ? 1 : (SECURITY_MODE == 5) ? 2 : 0;

  localparam int SIZE_H   = (MODE_IDX == 2) ? 504 : 252;
  localparam int SIZE_HB  = (MODE_IDX == 0) ? 37 : (MODE_IDX == 1) ? 71 : 175;
  localparam int START_H  = (MODE_IDX == 0) ? 248 : (MODE_IDX == 1) ? 246 : 492;
  localparam int START_HB = (MODE_IDX == 0) ? 14 : (MODE_IDX == 1) ? 29 : 81;
  localparam int COUNT_H  = (MODE_IDX == 0) ? 9 : (MODE_IDX == 1) ? 13 : 25;
  localparam int COUNT_HB = (MODE_IDX == 0) ? 9 : 13;
  localparam int OFF_H    = (MODE_IDX == 0) ? 0 : (MODE_IDX == 1) ? 18 : 44;
  localparam int OFF_HB   = (MODE_IDX == 0) ? 9 : (MODE_IDX == 1) ? 31 : 69;

  localparam int ROM_DEPTH = SIZE_H + SIZE_HB;
  localparam int ROM_AW    = $clog2(ROM_DEPTH);

  localparam int SYM_W    = 10;
  localparam int FREQ_W   = 16;
  localparam int CUM_W    = 17;
  localparam int STATE_W  = 32;
  localparam int BYTE_W   = 8;
  localparam int N_CORE   = 82;

  // Renormalization bound is freq times this power of two.
  localparam int RENORM_SHIFT = 23 - PROB_BITS + 8;
  localparam int CMP_W = (FREQ_W + RENORM_SHIFT > STATE_W) ? FREQ_W + RENORM_SHIFT : STATE_W;

  localparam logic [SYM_W:0]   HALF_HB  = (SYM_W + 1)'(SIZE_HB / 2);
  localparam logic [SYM_W:0]   BASE_HB  = (SYM_W + 1)'(SIZE_H);
  localparam logic [SYM_W-1:0] SIZE_H_V  = SYM_W'(SIZE_H);
  localparam logic [SYM_W-1:0] SIZE_HB_V = SYM_W'(SIZE_HB);

  localparam logic [FREQ_W-1:0] CORE_VALS [N_CORE] = '{
    16'd9, 16'd325, 16'd3772, 16'd15873, 16'd25334, 16'd15860, 16'd3780, 16'd330, 16'd10,
    16'd4, 16'd235, 16'd3305, 16'd15833, 16'd26660, 16'd15892, 16'd3334, 16'd240, 16'd5,
    16'd4, 16'd68, 16'd500, 16'd2375, 16'd7185, 16'd13930, 16'd17149, 16'd13965, 16'd7177,
    16'd2376, 16'd496, 16'd67, 16'd5,
    16'd4, 16'd55, 16'd444, 16'd2231, 16'd7047, 16'd14084, 16'd17706, 16'd14067, 16'd7084,
    16'd2254, 16'd443, 16'd56, 16'd3,
    16'd4, 16'd14, 16'd41, 16'd115, 16'd281, 16'd628, 16'd1247, 16'd2247, 16'd3651,
    16'd5288, 16'd6923, 16'd8085, 16'd8061, 16'd8117, 16'd6881, 16'd5275, 16'd3639,
    16'd2241, 16'd1249, 16'd616, 16'd281, 16'd114, 16'd43, 16'd13, 16'd3,
    16'd8, 16'd89, 16'd589, 16'd2561, 16'd7297, 16'd13713, 16'd16776, 16'd13740, 16'd7347,
    16'd2569, 16'd589, 16'd88, 16'd8
  };

  typedef logic [FREQ_W-1:0] freq_tab_t [ROM_DEPTH];
  typedef logic [CUM_W-1:0]  cum_tab_t  [ROM_DEPTH];

  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic [CUM_W-1:0]  cum;
  } rse_entry_t;

  function automatic freq_tab_t rse_build_freq();
    freq_tab_t t;
    for (int i = 0; i < ROM_DEPTH; i++) begin
      t[i] = FREQ_W'(1);
    end
    for (int i = 0; i < COUNT_H; i++) begin
      t[(START_H + i) % SIZE_H] = CORE_VALS[OFF_H + i];
    end
    for (int i = 0; i < COUNT_HB; i++) begin
      t[SIZE_H + (START_HB + i) % SIZE_HB] = CORE_VALS[OFF_HB + i];
    end
    return t;
  endfunction

  function automatic cum_tab_t rse_build_cum();
    freq_tab_t f;
    cum_tab_t  c;
    int        acc;
    f   = rse_build_freq();
    acc = 0;
    for (int i = 0; i < ROM_DEPTH; i++) begin
      if (i == SIZE_H) begin
        acc = 0;
      end
      c[i] = CUM_W'(acc);
      acc  = acc + int'(f[i]);
    end
    return c;
  endfunction

endpackage

// ----- hw/rtl/rse_rom.sv -----
// Frequency and cumulative-frequency tables of both alphabets, registered read.
// Depends on rse_pkg for table contents and the entry type.
module rse_rom import rse_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [ROM_AW-1:0] addr,
  output rse_entry_t        entry
);

  localparam freq_tab_t FREQ_TAB = rse_build_freq();
  localparam cum_tab_t  CUM_TAB  = rse_build_cum();

  always_ff @(posedge clk) begin
    if (en) begin
      entry <= '{freq: FREQ_TAB[addr], cum: CUM_TAB[addr]};
    end
  end

endmodule

// ----- hw/rtl/rse_div.sv -----
// Radix-2 restoring divider: one quotient bit per cycle, 32 steps, done registered with the last step.
// Depends on rse_pkg for widths.
module rse_div import rse_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [STATE_W-1:0] dividend,
  input  logic [FREQ_W-1:0]  divisor,
  output logic               done,
  output logic [STATE_W-1:0] quotient,
  output logic [FREQ_W-1:0]  remainder
);

  localparam int CNT_W = $clog2(STATE_W);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [STATE_W-1:0] q_r, q_nxt;
  logic [FREQ_W-1:0]  rem_r, rem_nxt;
  logic [FREQ_W-1:0]  dsr_r, dsr_nxt;
  logic [FREQ_W:0]    partial;
  logic               fits;

  assign partial = {rem_r, q_r[STATE_W-1]};
  assign fits    = partial >= {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      q_nxt    = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? FREQ_W'(partial - {1'b0, dsr_r}) : partial[FREQ_W-1:0];
      q_nxt   = {q_r[STATE_W-2:0], fits};
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(STATE_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done      = done_r;
  assign quotient  = q_r;
  assign remainder = rem_r;

endmodule

// ----- hw/rtl/rans_static_encoder.sv -----
// Top level of the static-table byte-wise rANS encoder: sequencer, coder state, output stage.
// Depends on rse_pkg, rse_rom and rse_div.
//
// An encode beat is accepted in S_IDLE, gets its range check and table read in S_CHECK, emits
// its n renormalization bytes (n is 0 to 4) in S_RENORM, and then waits in S_DIVIDE for the
// radix-2 divider that forms state / freq and state % freq. An out-of-range symbol returns from
// S_CHECK to S_IDLE and a flush passes through S_FLUSH. The input is not ready while a beat is
// in progress, and a slow result consumer can stall S_CHECK, S_RENORM and S_FLUSH.
module rans_static_encoder import rse_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [9:0] symbol_value, [15:10] zero
  input  logic [1:0]  in_tuser,   // [0] action, [1] alphabet
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_byte
  output logic [1:0]  out_tuser,  // [0] byte_valid, [1] symbol_error
  output logic        out_tlast
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_RENORM,
    S_DIVIDE,
    S_FLUSH
  } state_t;

  state_t             state_r, state_nxt;
  logic [STATE_W-1:0] x_r, x_nxt;
  logic [2:0]         cnt_r, cnt_nxt;
  logic               pend_v_r, pend_v_nxt;
  logic [BYTE_W-1:0]  pend_r, pend_nxt;
  logic               flush_r, flush_nxt;
  logic               alph_r, alph_nxt;
  logic [SYM_W-1:0]   sym_r, sym_nxt;
  logic               ovalid_r, ovalid_nxt;
  logic [BYTE_W-1:0]  obyte_r, obyte_nxt;
  logic [1:0]         ouser_r, ouser_nxt;
  logic               olast_r, olast_nxt;

  logic               out_free;
  logic [SYM_W:0]     s_val;
  logic [SYM_W:0]     addr_full;
  logic               sym_ok;
  logic               rom_en;
  rse_entry_t         entry;
  logic               ge;
  logic               div_start;
  logic               div_done;
  logic [STATE_W-1:0] quot;
  logic [FREQ_W-1:0]  rem;

  assign out_free  = !ovalid_r || out_tready;
  assign s_val     = {sym_r[SYM_W-1], sym_r} + (alph_r ? HALF_HB : '0);
  assign sym_ok    = !s_val[SYM_W] && (s_val[SYM_W-1:0] < (alph_r ? SIZE_HB_V : SIZE_H_V));
  assign addr_full = alph_r ? s_val + BASE_HB : s_val;
  assign rom_en    = (state_r == S_CHECK);
  assign ge        = (CMP_W'(x_r) >= (CMP_W'(entry.freq) << RENORM_SHIFT)) && (cnt_r < 3'd4);

  rse_rom u_rom (
    .clk   (clk),
    .en    (rom_en),
    .addr  (addr_full[ROM_AW-1:0]),
    .entry (entry)
  );

  rse_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (x_r),
    .divisor   (entry.freq),
    .done      (div_done),
    .quotient  (quot),
    .remainder (rem)
  );

  always_comb begin
    state_nxt  = state_r;
    x_nxt      = x_r;
    cnt_nxt    = cnt_r;
    pend_v_nxt = pend_v_r;
    pend_nxt   = pend_r;
    flush_nxt  = flush_r;
    alph_nxt   = alph_r;
    sym_nxt    = sym_r;
    ovalid_nxt = ovalid_r && !out_tready;
    obyte_nxt  = obyte_r;
    ouser_nxt  = ouser_r;
    olast_nxt  = olast_r;
    div_start  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          flush_nxt = in_tuser[0];
          alph_nxt  = in_tuser[1];
          sym_nxt   = in_tdata[SYM_W-1:0];
          cnt_nxt   = '0;
          pend_v_nxt = 1'b0;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (flush_r) begin
          state_nxt = S_FLUSH;
        end else if (sym_ok) begin
          state_nxt = S_RENORM;
        end else if (out_free) begin
          ovalid_nxt = 1'b1;
          obyte_nxt  = '0;
          ouser_nxt  = 2'b10;
          olast_nxt  = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_RENORM: begin
        if (ge) begin
          if (!pend_v_r || out_free) begin
            if (pend_v_r) begin
              ovalid_nxt = 1'b1;
              obyte_nxt  = pend_r;
              ouser_nxt  = 2'b01;
              olast_nxt  = 1'b0;
            end
            pend_nxt   = x_r[BYTE_W-1:0];
            pend_v_nxt = 1'b1;
            x_nxt      = x_r >> BYTE_W;
            cnt_nxt    = cnt_r + 3'd1;
          end
        end else if (out_free) begin
          ovalid_nxt = 1'b1;
          obyte_nxt  = pend_v_r ? pend_r : '0;
          ouser_nxt  = {1'b0, pend_v_r};
          olast_nxt  = 1'b1;
          pend_v_nxt = 1'b0;
          div_start  = 1'b1;
          state_nxt  = S_DIVIDE;
        end
      end
      S_DIVIDE: begin
        if (div_done) begin
          x_nxt     = (quot << PROB_BITS) + STATE_W'(rem) + STATE_W'(entry.cum);
          state_nxt = S_IDLE;
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          obyte_nxt  = x_r[STATE_W-1 -: BYTE_W];
          ouser_nxt  = 2'b01;
          olast_nxt  = (cnt_r == 3'd3);
          x_nxt      = x_r << BYTE_W;
          cnt_nxt    = cnt_r + 3'd1;
          if (cnt_r == 3'd3) begin
            x_nxt     = LOW_BOUND;
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      x_r      <= LOW_BOUND;
      cnt_r    <= '0;
      pend_v_r <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      x_r      <= x_nxt;
      cnt_r    <= cnt_nxt;
      pend_v_r <= pend_v_nxt;
      ovalid_r <= ovalid_nxt;
    end
    pend_r  <= pend_nxt;
    flush_r <= flush_nxt;
    alph_r  <= alph_nxt;
    sym_r   <= sym_nxt;
    obyte_r <= obyte_nxt;
    ouser_r <= ouser_nxt;
    olast_r <= olast_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ovalid_r;
  assign out_tdata  = obyte_r;
  assign out_tuser  = ouser_r;
  assign out_tlast  = olast_r;

endmodule

// ----- hw/rtl/rse_checker.sv -----
// Port-level checks for rans_static_encoder, attached to it by the bind below.
// Depends only on the top-level port list.
module rse_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [15:0] in_tdata,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  // A coded byte never carries the error flag.
  a_byte_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> !out_tuser[1])
    else $error("coded beat flagged as symbol error");

  // A beat without a byte is the only result of its input and carries a zero byte.
  a_nobyte_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tlast && (out_tdata == 8'd0))
    else $error("byte-less beat not a lone final zero beat");

  // The encoder works on one input beat at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready right after an accepted beat");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
      && $stable(out_tlast))
    else $error("stalled output beat changed");

endmodule

bind rans_static_encoder rse_checker u_rse_checker (.*);

// ----- tb/testbench.sv -----
// Self-checking testbench for the static-table byte-wise rANS encoder (rans_static_encoder).
// It predicts every coded byte from its own copy of the frequency tables and coder state.
// Depends on rse_pkg and the encoder RTL only.
module testbench;
  import rse_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic {ACT_ENCODE = 1'b0, ACT_FLUSH = 1'b1} action_e;
  typedef enum logic {ALPH_H = 1'b0, ALPH_HB = 1'b1} alph_e;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       byte_vld;
    logic       sym_err;
    logic       last_flag;
  } coded_beat_t;

  localparam int MAX_GAP  = 14;
  localparam int END_HOLD = 80;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  logic [FREQ_W-1:0] freq_tab [ROM_DEPTH];
  logic [CUM_W-1:0]  cum_tab  [ROM_DEPTH];
  logic [31:0]       rans_x;
  coded_beat_t       coded_q [$];

  bit tx_idle_on;
  bit rx_idle_on;
  int rx_hold;
  int mismatch_cnt;
  int beats_checked;
  int n_encoded;
  int n_flushed;
  int n_rejected;

  rans_static_encoder i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void load_tables();
    int acc;
    for (int i = 0; i < ROM_DEPTH; i++) begin
      freq_tab[i] = FREQ_W'(1);
    end
    for (int k = 0; k < COUNT_H; k++) begin
      freq_tab[(START_H + k) % SIZE_H] = CORE_VALS[OFF_H + k];
    end
    for (int k = 0; k < COUNT_HB; k++) begin
      freq_tab[SIZE_H + (START_HB + k) % SIZE_HB] = CORE_VALS[OFF_HB + k];
    end
    acc = 0;
    for (int i = 0; i < SIZE_H; i++) begin
      cum_tab[i] = CUM_W'(acc);
      acc += int'(freq_tab[i]);
    end
    acc = 0;
    for (int i = 0; i < SIZE_HB; i++) begin
      cum_tab[SIZE_H + i] = CUM_W'(acc);
      acc += int'(freq_tab[SIZE_H + i]);
    end
  endfunction

  function automatic void rans_encode_step(action_e act, alph_e alph, logic [9:0] sym);
    logic [63:0] x;
    logic [63:0] f;
    logic [63:0] bound;
    int          s;
    int          size;
    int          base;
    int          n;
    coded_beat_t b;
    if (act == ACT_FLUSH) begin
      for (int k = 3; k >= 0; k--) begin
        b = '{code_byte: rans_x[8*k +: 8], byte_vld: 1'b1, sym_err: 1'b0,
              last_flag: (k == 0)};
        coded_q.push_back(b);
      end
      rans_x = LOW_BOUND;
      n_flushed++;
      return;
    end
    size = (alph == ALPH_HB) ? SIZE_HB : SIZE_H;
    base = (alph == ALPH_HB) ? SIZE_H : 0;
    s = int'($signed(sym));
    if (alph == ALPH_HB) begin
      s += size / 2;
    end
    if (s < 0 || s >= size) begin
      coded_q.push_back('{code_byte: 8'd0, byte_vld: 1'b0, sym_err: 1'b1, last_flag: 1'b1});
      n_rejected++;
      return;
    end
    f = 64'(freq_tab[base + s]);
    if (f == 0) begin
      f = 1;
    end
    bound = ((64'(LOW_BOUND) >> PROB_BITS) << 8) * f;
    x = 64'(rans_x);
    n = 0;
    while (x >= bound && n < 4) begin
      coded_q.push_back('{code_byte: x[7:0], byte_vld: 1'b1, sym_err: 1'b0, last_flag: 1'b0});
      n++;
      x = x >> 8;
    end
    x = ((x / f) << PROB_BITS) + (x % f) + 64'(cum_tab[base + s]);
    rans_x = x[31:0];
    if (n == 0) begin
      coded_q.push_back('{code_byte: 8'd0, byte_vld: 1'b0, sym_err: 1'b0, last_flag: 1'b1});
    end else begin
      b = coded_q.pop_back();
      b.last_flag = 1'b1;
      coded_q.push_back(b);
    end
    n_encoded++;
  endfunction

  task automatic send_beat(action_e act, alph_e alph, logic [9:0] sym);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, sym};
    in_tuser  <= {alph, act};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    rans_encode_step(act, alph, sym);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (coded_q.size() != 0) @(posedge clk);
  endtask

  // Mostly symbols of the right alphabet, leaning on the high-probability core.
  task automatic send_random_item();
    int    r;
    alph_e alph;
    int    s;
    r = $urandom_range(0, 99);
    alph = alph_e'($urandom_range(0, 1));
    if (r < 6) begin
      send_beat(ACT_FLUSH, alph, 10'($urandom));
    end else if (r < 14) begin
      send_beat(ACT_ENCODE, alph, 10'($urandom));
    end else begin
      if (alph == ALPH_H) begin
        s = ($urandom_range(0, 1) == 1) ? (START_H + $urandom_range(0, COUNT_H - 1)) % SIZE_H
                                         : $urandom_range(0, SIZE_H - 1);
      end else begin
        s = ($urandom_range(0, 1) == 1) ? START_HB + $urandom_range(0, COUNT_HB - 1)
                                         : $urandom_range(0, SIZE_HB - 1);
        s -= SIZE_HB / 2;
      end
      send_beat(ACT_ENCODE, alph, 10'(s));
    end
  endtask

  task automatic test_directed();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    send_beat(ACT_FLUSH,  ALPH_H,  10'd0);
    send_beat(ACT_ENCODE, ALPH_H,  10'd0);
    send_beat(ACT_ENCODE, ALPH_H,  10'd251);
    send_beat(ACT_ENCODE, ALPH_H,  10'd5);
    send_beat(ACT_ENCODE, ALPH_H,  10'd247);
    send_beat(ACT_ENCODE, ALPH_H,  10'd252);
    send_beat(ACT_ENCODE, ALPH_H,  10'h1FF);
    send_beat(ACT_ENCODE, ALPH_H,  10'h3FF);
    send_beat(ACT_ENCODE, ALPH_H,  10'h200);
    send_beat(ACT_ENCODE, ALPH_HB, 10'(-18));
    send_beat(ACT_ENCODE, ALPH_HB, 10'd18);
    send_beat(ACT_ENCODE, ALPH_HB, 10'd0);
    send_beat(ACT_ENCODE, ALPH_HB, 10'(-19));
    send_beat(ACT_ENCODE, ALPH_HB, 10'd19);
    send_beat(ACT_ENCODE, ALPH_HB, 10'd503);
    send_beat(ACT_ENCODE, ALPH_HB, 10'(-87));
    send_beat(ACT_ENCODE, ALPH_H,  10'd100);
    send_beat(ACT_ENCODE, ALPH_H,  10'd100);
    send_beat(ACT_FLUSH,  ALPH_HB, 10'h3FF);
    send_beat(ACT_FLUSH,  ALPH_H,  10'h155);
    send_beat(ACT_ENCODE, ALPH_H,  10'd4);
    send_beat(ACT_ENCODE, ALPH_H,  10'd4);
    send_beat(ACT_ENCODE, ALPH_HB, 10'(-4));
    send_beat(ACT_ENCODE, ALPH_HB, 10'd4);
    send_beat(ACT_FLUSH,  ALPH_H,  10'd0);
  endtask

  task automatic test_random_idle(int count);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    for (int i = 0; i < count; i++) begin
      send_random_item();
    end
  endtask

  task automatic test_back_to_back(int count);
    for (int i = 0; i < count; i++) begin
      tx_idle_on = (i >= count / 2);
      rx_idle_on = (i < count / 4) || (i >= 3 * count / 4);
      send_random_item();
    end
  endtask

  // Short messages that each end in a flush, with the sender waiting for every byte.
  task automatic test_flushed_messages(int messages);
    int len;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    for (int m = 0; m < messages; m++) begin
      len = $urandom_range(1, 8);
      for (int i = 0; i < len; i++) begin
        send_random_item();
      end
      send_beat(ACT_FLUSH, alph_e'($urandom_range(0, 1)), 10'($urandom));
      wait_drained();
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_hold = 0;
    end else if (rx_hold > 0) begin
      rx_hold--;
      out_tready <= (rx_hold == 0);
    end else if (out_tvalid && out_tready) begin
      rx_hold = rx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
      out_tready <= (rx_hold == 0);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    coded_beat_t want;
    coded_beat_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{code_byte: out_tdata, byte_vld: out_tuser[0], sym_err: out_tuser[1],
              last_flag: out_tlast};
      if (coded_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
          $display("%0t: unexpected beat byte=%02h vld=%0b err=%0b last=%0b", $realtime,
                   got.code_byte, got.byte_vld, got.sym_err, got.last_flag);
        end
      end else begin
        want = coded_q.pop_front();
        beats_checked++;
        if (got !== want) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("%0t: beat %0d expected byte=%02h vld=%0b err=%0b last=%0b", $realtime,
                     beats_checked, want.code_byte, want.byte_vld, want.sym_err,
                     want.last_flag);
            $display("%0t: beat %0d actual   byte=%02h vld=%0b err=%0b last=%0b", $realtime,
                     beats_checked, got.code_byte, got.byte_vld, got.sym_err, got.last_flag);
          end
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d beats outstanding.", coded_q.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    load_tables();
    rans_x = LOW_BOUND;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_idle(90);
    test_back_to_back(60);
    test_flushed_messages(8);

    wait_drained();
    repeat (END_HOLD) @(posedge clk);
    $display("Encoded %0d symbols, flushed %0d times, rejected %0d symbols,", n_encoded,
             n_flushed, n_rejected);
    $display("checked %0d output beats, %0d mismatches.", beats_checked, mismatch_cnt);
    if (mismatch_cnt == 0 && coded_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
